@@ hdl/icmp_erc_pkg.sv @@
package icmp_erc_pkg;

   // Result codes; when several apply, the lowest nonzero one is reported.
   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      TOO_SHORT      = 3'd1,
      CHECKSUM_ERROR = 3'd2,
      NOT_ECHO_REPLY = 3'd3,
      FOREIGN_ID     = 3'd4
   } status_type;

   localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;
   localparam logic [15:0] SUM_GOOD        = 16'hFFFF;
   localparam logic [15:0] INDEX_MAX       = 16'hFFFF;
   localparam logic [31:0] MIN_TRIP_RESET  = 32'd65535;
   localparam logic [16:0] ICMP_HDR_BYTES  = 17'd8;

endpackage

@@ hdl/icmp_echo_reply_checker.sv @@
// ICMP echo reply checker.
// Input channel (req_*): one word per received IPv4 packet byte, with
// req_last_byte marking the final byte and req_now_ticks the current
// millisecond tick, sampled with the final byte. Accepted when req_valid
// is high and req_stall is low.
// Result channel (rsp_*): one word per packet, issued after its last byte:
// status, echoed sequence, trip time, ICMP payload length and the reply
// statistics after this packet. Taken when rsp_valid is high and rsp_stall
// is low.
// CSR channel (csr_*): writes own_id; csr_ready is always high. Write it
// only while no packet is in flight.
// Throughput: one byte per cycle while req_stall is low; only a last byte can stall.
// Three register levels: input register, verdict register, result register. A last
// byte's result passes through all three, and rsp_stall can hold it on the way.
// Reset (synchronous, active high) clears per-packet state, the statistics
// (fastest trip starts at 65535) and own_id.
// While rsp_stall holds a result, packet bytes keep flowing; only a last
// byte that finds both the verdict and the result register taken raises req_stall.
module icmp_echo_reply_checker
   import icmp_erc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // packet byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_now_ticks,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_echo_sequence,
   output logic [31:0] rsp_trip_time,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_replies_seen,
   output logic [31:0] rsp_fastest_trip,
   output logic [31:0] rsp_slowest_trip,
   output logic [31:0] rsp_summed_trip,
   // own_id register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_own_id
);

   // ---------------------------------------------------------------
   // Flow control
   // ---------------------------------------------------------------
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [31:0] in_now_ff;
   logic        ev_valid_ff, ev_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic out_take, out_free, ev_move, ev_free, in_move, req_take;

   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || out_take;
   assign ev_move   = ev_valid_ff && out_free;
   assign ev_free   = !ev_valid_ff || ev_move;
   // non-final bytes only touch packet state, so they never wait
   assign in_move   = in_valid_ff && (!in_last_ff || ev_free);
   assign req_stall = in_valid_ff && !in_move;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
   assign ev_valid_in  = (in_move && in_last_ff) ? 1'b1 : (ev_move ? 1'b0 : ev_valid_ff);
   assign rsp_valid_in = ev_move ? 1'b1 : (out_take ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_packet_byte;
         in_last_ff <= req_last_byte;
         in_now_ff  <= req_now_ticks;
      end
   end

   // ---------------------------------------------------------------
   // own_id register
   // ---------------------------------------------------------------
   logic [15:0] own_id_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_id_ff <= csr_own_id;
      end
   end

   // ---------------------------------------------------------------
   // Byte stage: field capture and one's-complement sum
   // ---------------------------------------------------------------
   logic [15:0] byte_index_ff, byte_index_in;
   logic [5:0]  header_length_ff, header_length_in;
   logic [15:0] ip_length_ff, ip_length_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  pending_byte_ff, pending_byte_in;
   logic [7:0]  message_type_ff, message_type_in;
   logic [15:0] message_id_ff, message_id_in;
   logic [15:0] message_seq_ff, message_seq_in;
   logic [31:0] send_stamp_ff, send_stamp_in;

   logic        past_header;
   logic [15:0] rel_index;
   logic        in_span;
   logic        do_add;
   logic [15:0] add_word;
   logic [16:0] sum_wide;
   logic [16:0] received;
   logic [16:0] min_length;
   logic [16:0] total17;
   status_type  status_new;
   logic [15:0] payload_new;
   logic [31:0] trip_new;

   always_comb begin
      header_length_in = header_length_ff;
      ip_length_in     = ip_length_ff;
      message_type_in  = message_type_ff;
      message_id_in    = message_id_ff;
      message_seq_in   = message_seq_ff;
      send_stamp_in    = send_stamp_ff;
      pending_byte_in  = pending_byte_ff;
      do_add           = 1'b0;
      add_word         = '0;

      // IP header: IHL nibble and big-endian total length
      unique case (byte_index_ff)
         16'd0:   header_length_in = {in_byte_ff[3:0], 2'b00};
         16'd2:   ip_length_in     = {in_byte_ff, ip_length_ff[7:0]};
         16'd3:   ip_length_in     = {ip_length_ff[15:8], in_byte_ff};
         default: ;
      endcase

      past_header = byte_index_ff >= {10'd0, header_length_in};
      rel_index   = byte_index_ff - {10'd0, header_length_in};

      // ICMP header fields; id, seq and stamp are little-endian
      if (past_header) begin
         unique case (rel_index)
            16'd0:   message_type_in        = in_byte_ff;
            16'd4:   message_id_in[7:0]     = in_byte_ff;
            16'd5:   message_id_in[15:8]    = in_byte_ff;
            16'd6:   message_seq_in[7:0]    = in_byte_ff;
            16'd7:   message_seq_in[15:8]   = in_byte_ff;
            16'd8:   send_stamp_in[7:0]     = in_byte_ff;
            16'd9:   send_stamp_in[15:8]    = in_byte_ff;
            16'd10:  send_stamp_in[23:16]   = in_byte_ff;
            16'd11:  send_stamp_in[31:24]   = in_byte_ff;
            default: ;
         endcase
      end

      // length is not known before byte 4, so bytes 0..3 always pass the length test
      in_span = past_header &&
                (byte_index_ff < 16'd4 || byte_index_ff < ip_length_in);
      if (in_span) begin
         priority if (byte_index_ff[0]) begin
            do_add   = 1'b1;
            add_word = {pending_byte_ff, in_byte_ff};
         end else if (byte_index_ff >= 16'd4 &&
                      ({1'b0, byte_index_ff} + 17'd1) == {1'b0, ip_length_in}) begin
            // odd trailing byte, zero padded
            do_add   = 1'b1;
            add_word = {in_byte_ff, 8'd0};
         end else begin
            pending_byte_in = in_byte_ff;
         end
      end

      // end-around carry; the wrapped sum never overflows 16 bits
      sum_wide       = {1'b0, running_sum_ff} + {1'b0, add_word};
      running_sum_in = do_add ? (sum_wide[15:0] + {15'd0, sum_wide[16]}) : running_sum_ff;

      byte_index_in  = (byte_index_ff == INDEX_MAX) ? byte_index_ff : byte_index_ff + 16'd1;

      // verdict, only used with the last byte
      received   = {1'b0, byte_index_ff} + 17'd1;
      min_length = {11'd0, header_length_in} + ICMP_HDR_BYTES;
      total17    = {1'b0, ip_length_in};
      priority if (received < min_length || total17 > received || total17 < min_length) begin
         status_new = TOO_SHORT;
      end else if (running_sum_in != SUM_GOOD) begin
         status_new = CHECKSUM_ERROR;
      end else if (message_type_in != ECHO_REPLY_TYPE) begin
         status_new = NOT_ECHO_REPLY;
      end else if (message_id_in != own_id_ff) begin
         status_new = FOREIGN_ID;
      end else begin
         status_new = STATUS_OK;
      end

      payload_new = ip_length_in - {10'd0, header_length_in} - 16'd8;
      trip_new    = in_now_ff - send_stamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= '0;
         header_length_ff <= '0;
         ip_length_ff     <= '0;
         running_sum_ff   <= '0;
         pending_byte_ff  <= '0;
         message_type_ff  <= '0;
         message_id_ff    <= '0;
         message_seq_ff   <= '0;
         send_stamp_ff    <= '0;
      end else if (in_move) begin
         if (in_last_ff) begin
            // packet done: back to a clean slate
            byte_index_ff    <= '0;
            header_length_ff <= '0;
            ip_length_ff     <= '0;
            running_sum_ff   <= '0;
            pending_byte_ff  <= '0;
            message_type_ff  <= '0;
            message_id_ff    <= '0;
            message_seq_ff   <= '0;
            send_stamp_ff    <= '0;
         end else begin
            byte_index_ff    <= byte_index_in;
            header_length_ff <= header_length_in;
            ip_length_ff     <= ip_length_in;
            running_sum_ff   <= running_sum_in;
            pending_byte_ff  <= pending_byte_in;
            message_type_ff  <= message_type_in;
            message_id_ff    <= message_id_in;
            message_seq_ff   <= message_seq_in;
            send_stamp_ff    <= send_stamp_in;
         end
      end
   end

   // verdict register
   status_type  ev_status_ff;
   logic [15:0] ev_seq_ff;
   logic [31:0] ev_trip_ff;
   logic [15:0] ev_payload_ff;

   always_ff @(posedge clock) begin
      if (in_move && in_last_ff) begin
         ev_status_ff  <= status_new;
         ev_seq_ff     <= message_seq_in;
         ev_trip_ff    <= trip_new;
         ev_payload_ff <= payload_new;
      end
   end

   // ---------------------------------------------------------------
   // Statistics and result register
   // ---------------------------------------------------------------
   logic        ev_ok;
   logic [31:0] count_ff, count_in;
   logic [31:0] min_trip_ff, min_trip_in;
   logic [31:0] max_trip_ff, max_trip_in;
   logic [31:0] total_trip_ff, total_trip_in;
   status_type  rsp_status_ff;
   logic [15:0] rsp_seq_ff;
   logic [31:0] rsp_trip_ff;
   logic [15:0] rsp_payload_ff;

   assign ev_ok         = ev_status_ff == STATUS_OK;
   assign count_in      = count_ff + 32'd1;
   assign total_trip_in = total_trip_ff + ev_trip_ff;
   assign min_trip_in   = (min_trip_ff > ev_trip_ff) ? ev_trip_ff : min_trip_ff;
   assign max_trip_in   = (max_trip_ff < ev_trip_ff) ? ev_trip_ff : max_trip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         min_trip_ff   <= MIN_TRIP_RESET;
         max_trip_ff   <= '0;
         total_trip_ff <= '0;
      end else if (ev_move && ev_ok) begin
         count_ff      <= count_in;
         min_trip_ff   <= min_trip_in;
         max_trip_ff   <= max_trip_in;
         total_trip_ff <= total_trip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_move) begin
         rsp_status_ff  <= ev_status_ff;
         rsp_seq_ff     <= ev_ok ? ev_seq_ff : 16'd0;
         rsp_trip_ff    <= ev_ok ? ev_trip_ff : 32'd0;
         rsp_payload_ff <= ev_ok ? ev_payload_ff : 16'd0;
      end
   end

   // stats only move together with a new result word, so they can be
   // shown straight from the accumulators
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_echo_sequence  = rsp_seq_ff;
   assign rsp_trip_time      = rsp_trip_ff;
   assign rsp_payload_length = rsp_payload_ff;
   assign rsp_replies_seen   = count_ff;
   assign rsp_fastest_trip   = min_trip_ff;
   assign rsp_slowest_trip   = max_trip_ff;
   assign rsp_summed_trip    = total_trip_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // only a last byte with no room downstream may hold up the input
   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && ev_valid_ff))
      else $error("input stalled without a waiting last byte");

   // a verdict that moves must show up as a result word
   a_verdict_issued: assert property (@(posedge clock) disable iff (reset)
      ev_move |=> rsp_valid)
      else $error("verdict lost on its way to the result register");

   // failed packets carry no measurement
   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
      (rsp_trip_time == 32'd0 && rsp_echo_sequence == 16'd0 &&
       rsp_payload_length == 16'd0))
      else $error("failed packet reports trip data");

   // once replies were counted, fastest never exceeds slowest
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_replies_seen != 32'd0) |-> (rsp_fastest_trip <= rsp_slowest_trip))
      else $error("fastest trip above slowest trip");

endmodule
